// ===== rtl/core/slcf_pkg.sv =====
`default_nettype none

package slcf_pkg;

	// Largest frame on the line: sync pair, length, body and checksum.
	localparam int unsigned MAX_FRAME = 64;

	localparam logic [7:0] SYNC_HI = 8'hFF;
	localparam logic [7:0] SYNC_LO = 8'h00;

	typedef enum logic [1:0] {
		ACT_TX_START = 2'd0,
		ACT_TX_DATA  = 2'd1,
		ACT_RX_BYTE  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		KIND_TX     = 2'd0,
		KIND_RX     = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_HEADER = 2'd1,
		ST_TOO_LONG   = 2'd2,
		ST_BAD_SUM    = 2'd3
	} status_t;

	// How the back end expands one queued entry into beats.
	typedef enum logic [1:0] {
		OP_TX_HDR    = 2'd0,
		OP_TX_DATA   = 2'd1,
		OP_RX_BYTE   = 2'd2,
		OP_RX_STATUS = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] command_code;
		logic [5:0] data_count;
		logic [7:0] byte_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_byte;
		logic [1:0] frame_status;
		logic       last;
	} out_item_t;

	// One classified item. byte0 is the length or data byte, byte1 the
	// command, sum the checksum to append; tail adds the trailing beat.
	typedef struct packed {
		op_t        op;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] sum;
		logic [1:0] status;
		logic       tail;
	} entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/slcf_front.sv =====
`default_nettype none

module slcf_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire slcf_pkg::in_item_t item,
	input  wire logic              q_full,
	output logic                   q_wr,
	output slcf_pkg::entry_t       q_entry
);

	typedef enum logic [4:0] {
		PH_HUNT  = 5'b00001,
		PH_SYNC2 = 5'b00010,
		PH_LEN   = 5'b00100,
		PH_BODY  = 5'b01000,
		PH_SUM   = 5'b10000
	} rx_phase_t;

	rx_phase_t  rx_phase_q, rx_phase_d;
	logic [7:0] rx_remaining_q, rx_remaining_d;
	logic [7:0] rx_sum_q, rx_sum_d;
	logic [7:0] tx_sum_q, tx_sum_d;
	logic [5:0] tx_remaining_q, tx_remaining_d;
	logic       accept;
	logic [7:0] b;
	logic [7:0] len;
	logic [7:0] tx_sum_next;
	logic       too_long;

	assign accept      = push && !q_full;
	assign b           = item.byte_value;
	assign len         = {2'b00, item.data_count} + 8'd1;
	assign tx_sum_next = tx_sum_q + b;
	assign too_long    = ({1'b0, b} + 9'd4) > 9'(slcf_pkg::MAX_FRAME);

	always_comb begin
		rx_phase_d     = rx_phase_q;
		rx_remaining_d = rx_remaining_q;
		rx_sum_d       = rx_sum_q;
		tx_sum_d       = tx_sum_q;
		tx_remaining_d = tx_remaining_q;
		q_wr           = 1'b0;
		q_entry        = '{op: slcf_pkg::OP_RX_STATUS, byte0: b, byte1: item.command_code,
			sum: 8'd0, status: slcf_pkg::ST_OK, tail: 1'b0};
		case (item.action)
			slcf_pkg::ACT_TX_START: begin
				q_wr           = 1'b1;
				q_entry.op     = slcf_pkg::OP_TX_HDR;
				q_entry.byte0  = len;
				q_entry.sum    = len + item.command_code;
				q_entry.tail   = (item.data_count == 6'd0);
				tx_sum_d       = len + item.command_code;
				tx_remaining_d = item.data_count;
			end
			slcf_pkg::ACT_TX_DATA: begin
				if (tx_remaining_q != 6'd0) begin
					q_wr           = 1'b1;
					q_entry.op     = slcf_pkg::OP_TX_DATA;
					q_entry.sum    = tx_sum_next;
					q_entry.tail   = (tx_remaining_q == 6'd1);
					tx_sum_d       = tx_sum_next;
					tx_remaining_d = tx_remaining_q - 6'd1;
				end
			end
			slcf_pkg::ACT_RX_BYTE: begin
				case (rx_phase_q)
					PH_SYNC2: begin
						if (b == slcf_pkg::SYNC_LO) begin
							rx_phase_d = PH_LEN;
						end else begin
							q_wr           = 1'b1;
							q_entry.status = slcf_pkg::ST_BAD_HEADER;
							rx_phase_d     = (b == slcf_pkg::SYNC_HI) ? PH_SYNC2 : PH_HUNT;
						end
					end
					PH_LEN: begin
						q_wr       = 1'b1;
						q_entry.op = slcf_pkg::OP_RX_BYTE;
						if (too_long) begin
							q_entry.tail   = 1'b1;
							q_entry.status = slcf_pkg::ST_TOO_LONG;
							rx_phase_d     = PH_HUNT;
							rx_remaining_d = 8'd0;
							rx_sum_d       = 8'd0;
						end else begin
							rx_sum_d       = b;
							rx_remaining_d = b;
							rx_phase_d     = (b == 8'd0) ? PH_SUM : PH_BODY;
						end
					end
					PH_BODY: begin
						q_wr           = 1'b1;
						q_entry.op     = slcf_pkg::OP_RX_BYTE;
						rx_sum_d       = rx_sum_q + b;
						rx_remaining_d = rx_remaining_q - 8'd1;
						if (rx_remaining_q == 8'd1) begin
							rx_phase_d = PH_SUM;
						end
					end
					PH_SUM: begin
						q_wr           = 1'b1;
						q_entry.status = (b == rx_sum_q) ? slcf_pkg::ST_OK
							: slcf_pkg::ST_BAD_SUM;
						rx_phase_d     = PH_HUNT;
						rx_remaining_d = 8'd0;
						rx_sum_d       = 8'd0;
					end
					default: begin
						rx_phase_d = (b == slcf_pkg::SYNC_HI) ? PH_SYNC2 : PH_HUNT;
					end
				endcase
			end
			default: begin
			end
		endcase
		if (!accept) begin
			q_wr = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_phase_q     <= PH_HUNT;
			rx_remaining_q <= 8'd0;
			rx_sum_q       <= 8'd0;
			tx_sum_q       <= 8'd0;
			tx_remaining_q <= 6'd0;
		end else if (accept) begin
			rx_phase_q     <= rx_phase_d;
			rx_remaining_q <= rx_remaining_d;
			rx_sum_q       <= rx_sum_d;
			tx_sum_q       <= tx_sum_d;
			tx_remaining_q <= tx_remaining_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/slcf_queue.sv =====
`default_nettype none

module slcf_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire slcf_pkg::entry_t wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output slcf_pkg::entry_t      rd_data,
	output logic                  empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	slcf_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full) else $error("entry queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty) else $error("entry queue read while empty");

endmodule

`default_nettype wire

// ===== rtl/core/slcf_back.sv =====
`default_nettype none

module slcf_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire slcf_pkg::entry_t  q_head,
	output logic                   q_rd,
	input  wire logic              pop,
	output logic                   empty,
	output slcf_pkg::out_item_t    result
);

	logic [2:0]          idx_q;
	logic                out_valid_q;
	slcf_pkg::out_item_t result_q;
	slcf_pkg::out_item_t beat;
	logic                final_beat;
	logic                advance;

	// Beat number idx_q of the entry at the head of the queue.
	always_comb begin
		beat       = '{out_kind: slcf_pkg::KIND_TX, out_byte: 8'd0,
			frame_status: slcf_pkg::ST_OK, last: 1'b0};
		final_beat = 1'b0;
		case (q_head.op)
			slcf_pkg::OP_TX_HDR: begin
				final_beat = (idx_q == (q_head.tail ? 3'd4 : 3'd3));
				case (idx_q)
					3'd0: beat.out_byte = slcf_pkg::SYNC_HI;
					3'd1: beat.out_byte = slcf_pkg::SYNC_LO;
					3'd2: beat.out_byte = q_head.byte0;
					3'd3: beat.out_byte = q_head.byte1;
					default: begin
						beat.out_byte = q_head.sum;
						beat.last     = 1'b1;
					end
				endcase
			end
			slcf_pkg::OP_TX_DATA: begin
				final_beat = (idx_q == (q_head.tail ? 3'd1 : 3'd0));
				if (idx_q == 3'd0) begin
					beat.out_byte = q_head.byte0;
				end else begin
					beat.out_byte = q_head.sum;
					beat.last     = 1'b1;
				end
			end
			slcf_pkg::OP_RX_BYTE: begin
				final_beat = (idx_q == (q_head.tail ? 3'd1 : 3'd0));
				if (idx_q == 3'd0) begin
					beat.out_kind = slcf_pkg::KIND_RX;
					beat.out_byte = q_head.byte0;
				end else begin
					beat.out_kind     = slcf_pkg::KIND_STATUS;
					beat.frame_status = q_head.status;
					beat.last         = 1'b1;
				end
			end
			default: begin
				final_beat        = 1'b1;
				beat.out_kind     = slcf_pkg::KIND_STATUS;
				beat.frame_status = q_head.status;
				beat.last         = 1'b1;
			end
		endcase
	end

	assign advance = !q_empty && (!out_valid_q || pop);
	assign q_rd    = advance && final_beat;
	assign empty   = !out_valid_q;
	assign result  = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				idx_q       <= final_beat ? 3'd0 : idx_q + 3'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= beat;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= 3'd4) else $error("beat index past the longest entry");

	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 3'd0 |-> !q_empty) else $error("entry left the queue mid expansion");

endmodule

`default_nettype wire

// ===== rtl/core/sync_length_checksum_framer.sv =====
// Serial-link framing engine with a transmit side and a receive side sharing one
// input queue port and one result queue port.
// Input beats (push/full) carry an action: start a transmit frame, add a transmit
// data byte, or present one received line byte. A start expands into sync 0xFF,
// 0x00, length, command and, for an empty frame, the checksum; each data byte
// yields itself and, on the last one, the checksum with last set.
// Received bytes are hunted for the sync pair; length and data bytes come out
// as provisional frame bytes, followed by a status beat (ok, bad header, too long
// or bad checksum) with last set.
// Results (empty/pop): the oldest beat is on result while empty is low.
// The front end classifies one item per cycle while full is low and updates
// the framing state; a small entry queue feeds the back end, which emits one
// beat per cycle into an output register unless a held beat waits for pop.
// An item's first beat reaches result through the entry queue and then the
// output register. Receive bytes sustain one item per cycle while pop stays
// high; a start yields four or five beats, so full rises as the queue backs up.
// When the receiver holds pop low, the output register holds its beat, the
// queue fills, and full stalls the sender without losing any beat.
// Reset empties the queue and output register, closes any transmit frame and
// returns the receiver to hunting for the first sync byte.
`default_nettype none

module sync_length_checksum_framer #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire slcf_pkg::in_item_t  item,
	output logic                     empty,
	input  wire logic                pop,
	output slcf_pkg::out_item_t      result
);

	logic             q_wr;
	logic             q_rd;
	logic             q_empty;
	slcf_pkg::entry_t q_wr_entry;
	slcf_pkg::entry_t q_head;

	slcf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.q_full  (full),
		.q_wr    (q_wr),
		.q_entry (q_wr_entry)
	);

	slcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wr_entry),
		.full    (full),
		.rd_en   (q_rd),
		.rd_data (q_head),
		.empty   (q_empty)
	);

	slcf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

`default_nettype wire

// ===== tb/tb_sync_length_checksum_framer.sv =====
`timescale 1ns / 100ps

// Testbench for the framing engine. A driver feeds items from a queue of
// pending items, and a monitor pops result beats. Both sides idle at random.
// Every accepted item runs through a behavioral model of the framer kept in
// this file. The model appends the beats that the item should produce to a
// queue, and the monitor checks each popped beat against the oldest entry.
module tb_sync_length_checksum_framer;

	// Receive framing phases of the model.
	typedef enum logic [2:0] {
		RX_HUNT  = 3'd0,
		RX_SYNC2 = 3'd1,
		RX_LEN   = 3'd2,
		RX_BODY  = 3'd3,
		RX_SUM   = 3'd4
	} rx_phase_t;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PERCENT = 29;
	localparam int SETTLE_CYCLES = 20;
	// Action code that the block does not use.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                full;
	slcf_pkg::in_item_t  item = '0;
	logic                empty;
	logic                pop = 1'b0;
	slcf_pkg::out_item_t result;

	// While calm is set, neither side idles.
	bit calm = 1'b0;
	int errors = 0;
	int cycles = 0;
	int stim_items = 0;

	slcf_pkg::in_item_t  pending_items[$];
	slcf_pkg::out_item_t expected_beats[$];

	// Model state: one copy for the receiver and one for the transmitter.
	rx_phase_t  rx_phase = RX_HUNT;
	logic [7:0] rx_left = '0;
	logic [7:0] rx_check = '0;
	logic [7:0] tx_check = '0;
	logic [5:0] tx_left = '0;

	sync_length_checksum_framer dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic void add_beat(slcf_pkg::kind_t kind, logic [7:0] value,
		slcf_pkg::status_t status, logic is_last);
		slcf_pkg::out_item_t beat;
		beat.out_kind = kind;
		beat.out_byte = value;
		beat.frame_status = status;
		beat.last = is_last;
		expected_beats = {expected_beats, beat};
	endfunction

	// Works out the beats that one accepted item produces and updates the
	// model state. The transmit and receive sides never interact.
	function automatic void predict_beats(slcf_pkg::in_item_t it);
		logic [7:0] len;
		case (it.action)
			slcf_pkg::ACT_TX_START: begin
				// A start always opens a fresh frame, even if one is still open.
				len = {2'b00, it.data_count} + 8'd1;
				add_beat(slcf_pkg::KIND_TX, slcf_pkg::SYNC_HI, slcf_pkg::ST_OK, 1'b0);
				add_beat(slcf_pkg::KIND_TX, slcf_pkg::SYNC_LO, slcf_pkg::ST_OK, 1'b0);
				add_beat(slcf_pkg::KIND_TX, len, slcf_pkg::ST_OK, 1'b0);
				add_beat(slcf_pkg::KIND_TX, it.command_code, slcf_pkg::ST_OK, 1'b0);
				tx_check = len + it.command_code;
				tx_left = it.data_count;
				if (tx_left == 6'd0)
					add_beat(slcf_pkg::KIND_TX, tx_check, slcf_pkg::ST_OK, 1'b1);
			end
			slcf_pkg::ACT_TX_DATA: begin
				// With no frame open, a data byte is dropped.
				if (tx_left != 6'd0) begin
					add_beat(slcf_pkg::KIND_TX, it.byte_value, slcf_pkg::ST_OK, 1'b0);
					tx_check = tx_check + it.byte_value;
					tx_left = tx_left - 6'd1;
					if (tx_left == 6'd0)
						add_beat(slcf_pkg::KIND_TX, tx_check, slcf_pkg::ST_OK, 1'b1);
				end
			end
			slcf_pkg::ACT_RX_BYTE: begin
				case (rx_phase)
					RX_SYNC2: begin
						if (it.byte_value == slcf_pkg::SYNC_LO) begin
							rx_phase = RX_LEN;
						end else begin
							// A second 0xFF counts as the first byte of a new sync pair.
							add_beat(slcf_pkg::KIND_STATUS, 8'h00, slcf_pkg::ST_BAD_HEADER,
								1'b1);
							rx_phase = (it.byte_value == slcf_pkg::SYNC_HI) ? RX_SYNC2
								: RX_HUNT;
						end
					end
					RX_LEN: begin
						add_beat(slcf_pkg::KIND_RX, it.byte_value, slcf_pkg::ST_OK, 1'b0);
						if (int'(it.byte_value) + 4 > slcf_pkg::MAX_FRAME) begin
							// The length goes out, then the frame is rejected at once.
							add_beat(slcf_pkg::KIND_STATUS, 8'h00, slcf_pkg::ST_TOO_LONG,
								1'b1);
							rx_phase = RX_HUNT;
							rx_left = '0;
							rx_check = '0;
						end else begin
							rx_check = it.byte_value;
							rx_left = it.byte_value;
							rx_phase = (it.byte_value == 8'd0) ? RX_SUM : RX_BODY;
						end
					end
					RX_BODY: begin
						add_beat(slcf_pkg::KIND_RX, it.byte_value, slcf_pkg::ST_OK, 1'b0);
						rx_check = rx_check + it.byte_value;
						rx_left = rx_left - 8'd1;
						if (rx_left == 8'd0)
							rx_phase = RX_SUM;
					end
					RX_SUM: begin
						add_beat(slcf_pkg::KIND_STATUS, 8'h00,
							(it.byte_value == rx_check) ? slcf_pkg::ST_OK
							: slcf_pkg::ST_BAD_SUM, 1'b1);
						rx_phase = RX_HUNT;
						rx_left = '0;
						rx_check = '0;
					end
					default: begin
						// While hunting, anything but 0xFF is line noise.
						rx_phase = (it.byte_value == slcf_pkg::SYNC_HI) ? RX_SYNC2
							: RX_HUNT;
					end
				endcase
			end
			default: begin
			end
		endcase
	endfunction

	// Queues one item. Fields that a start, data or receive action does not use
	// get random values, so that the block is seen to ignore them.
	function automatic void queue_item(logic [1:0] act, logic [7:0] cmd, logic [5:0] cnt,
		logic [7:0] value);
		slcf_pkg::in_item_t it;
		it.action = act;
		it.command_code = cmd;
		it.data_count = cnt;
		it.byte_value = value;
		if (act == slcf_pkg::ACT_TX_START) begin
			it.byte_value = 8'($urandom_range(0, 255));
		end else if (act == slcf_pkg::ACT_TX_DATA || act == slcf_pkg::ACT_RX_BYTE) begin
			it.command_code = 8'($urandom_range(0, 255));
			it.data_count = 6'($urandom_range(0, 60));
		end
		pending_items = {pending_items, it};
		stim_items++;
	endfunction

	// A transmit frame of count data bytes, of which only sent_bytes are given.
	// A short frame is left open, to be abandoned by the next start. Now and
	// then a received byte slips in between data bytes.
	function automatic void queue_tx_frame(int count, int sent_bytes);
		queue_item(slcf_pkg::ACT_TX_START, 8'($urandom_range(0, 255)), 6'(count), 8'h00);
		for (int i = 0; i < sent_bytes; i++) begin
			if ($urandom_range(0, 7) == 0)
				queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, 8'($urandom_range(0, 255)));
			queue_item(slcf_pkg::ACT_TX_DATA, 8'h00, 6'd0, 8'($urandom_range(0, 255)));
		end
	endfunction

	// A received frame with random body bytes. Its checksum is either right
	// or corrupted. Now and then the sync pair is broken.
	function automatic void queue_rx_frame(int len, bit good_sum);
		logic [7:0] check;
		logic [7:0] value;
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, slcf_pkg::SYNC_HI);
		if ($urandom_range(0, 19) == 0) begin
			queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, 8'($urandom_range(0, 255)));
			return;
		end
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, slcf_pkg::SYNC_LO);
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, 8'(len));
		if (len + 4 > slcf_pkg::MAX_FRAME)
			return;
		check = 8'(len);
		for (int i = 0; i < len; i++) begin
			value = 8'($urandom_range(0, 255));
			check = check + value;
			queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, value);
		end
		if (!good_sum)
			check = check ^ 8'($urandom_range(1, 255));
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, check);
	endfunction

	// Mostly well-formed frames with small sizes and a few large ones. The
	// rest is noise: random items of every action, including the unused one.
	function automatic void queue_random_traffic(int target);
		int goal;
		int pick;
		int size;
		int bursts;
		slcf_pkg::in_item_t junk;
		goal = stim_items + target;
		while (stim_items < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				size = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 6);
				queue_tx_frame(size, ($urandom_range(0, 9) == 0) ? $urandom_range(0, size) : size);
			end else if (pick < 85) begin
				pick = $urandom_range(0, 29);
				if (pick == 0)
					size = $urandom_range(61, 255);
				else if (pick == 1)
					size = $urandom_range(0, 60);
				else
					size = $urandom_range(0, 6);
				queue_rx_frame(size, $urandom_range(0, 6) != 0);
			end else begin
				bursts = $urandom_range(1, 3);
				for (int i = 0; i < bursts; i++) begin
					junk.action = 2'($urandom_range(0, 3));
					junk.command_code = 8'($urandom_range(0, 255));
					junk.data_count = 6'($urandom_range(0, 60));
					junk.byte_value = 8'($urandom_range(0, 255));
					pending_items = {pending_items, junk};
					stim_items++;
				end
			end
		end
	endfunction

	// Driver. The model runs at the edge where an item is accepted. The next
	// item is presented at the same edge, so push stays high across
	// back-to-back beats.
	always @(posedge clk or negedge arst_n) begin
		logic               push_nxt;
		slcf_pkg::in_item_t item_nxt;
		if (!arst_n) begin
			push <= 1'b0;
			item <= '0;
		end else begin
			push_nxt = push;
			item_nxt = item;
			if (push && !full) begin
				predict_beats(item);
				push_nxt = 1'b0;
			end
			if (!push_nxt && pending_items.size() != 0
				&& (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
				item_nxt = pending_items.pop_front();
				push_nxt = 1'b1;
			end
			push <= push_nxt;
			item <= item_nxt;
		end
	end

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	// Monitor. It compares every popped beat with the oldest expected beat and
	// stalls at random.
	always @(posedge clk or negedge arst_n) begin
		slcf_pkg::out_item_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_beats.size() == 0) begin
					$error("unexpected beat: kind %0d byte %0h status %0d last %0d",
						result.out_kind, result.out_byte, result.frame_status, result.last);
					errors++;
				end else begin
					want = expected_beats.pop_front();
					check_field("out_kind", 8'(want.out_kind), 8'(result.out_kind));
					check_field("out_byte", want.out_byte, result.out_byte);
					check_field("frame_status", 8'(want.frame_status),
						8'(result.frame_status));
					check_field("last", 8'(want.last), 8'(result.last));
				end
			end
			pop <= calm || $urandom_range(0, 99) >= IDLE_PERCENT;
		end
	end

	// Waits on falling edges, so that the driver has settled the edge before.
	task automatic drain_sender();
		while (pending_items.size() != 0 || push)
			@(negedge clk);
	endtask

	task automatic drain_results();
		while (expected_beats.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Transmit side. The frames are empty, short, and abandoned. There is
		// also a data byte with no frame open, and an item of the unused action.
		queue_item(slcf_pkg::ACT_TX_START, 8'hFF, 6'd0, 8'h00);
		queue_item(slcf_pkg::ACT_TX_DATA, 8'h00, 6'd0, 8'hAA);
		queue_item(ACT_UNUSED, 8'hFF, 6'd60, 8'hFF);
		queue_item(slcf_pkg::ACT_TX_START, 8'h00, 6'd2, 8'h00);
		queue_item(slcf_pkg::ACT_TX_DATA, 8'h00, 6'd0, 8'h00);
		queue_item(slcf_pkg::ACT_TX_DATA, 8'h00, 6'd0, 8'hFF);
		queue_item(slcf_pkg::ACT_TX_START, 8'hA5, 6'd3, 8'h00);
		queue_item(slcf_pkg::ACT_TX_DATA, 8'h00, 6'd0, 8'h5A);
		queue_item(slcf_pkg::ACT_TX_START, 8'h3C, 6'd1, 8'h00);
		queue_item(slcf_pkg::ACT_TX_DATA, 8'h00, 6'd0, 8'hC3);

		// Receive side. Noise comes while hunting. A bad sync falls back to
		// hunting, and a bad sync on 0xFF resyncs. Then come a zero-length
		// frame, a frame one byte too long, and a frame with a bad checksum.
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, 8'h12);
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, slcf_pkg::SYNC_HI);
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, 8'h37);
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, slcf_pkg::SYNC_HI);
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, slcf_pkg::SYNC_HI);
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, slcf_pkg::SYNC_LO);
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, 8'h00);
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, 8'h00);
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, slcf_pkg::SYNC_HI);
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, slcf_pkg::SYNC_LO);
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, 8'd61);
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, slcf_pkg::SYNC_HI);
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, slcf_pkg::SYNC_LO);
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, 8'h02);
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, 8'h10);
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, 8'h20);
		queue_item(slcf_pkg::ACT_RX_BYTE, 8'h00, 6'd0, 8'h55);

		// Hold off the sender until the directed part has fully drained.
		drain_sender();
		drain_results();

		// A transmit frame of 60 data bytes and the largest accepted receive frame, then
		// random traffic. The middle batch runs with no idling on either side.
		queue_tx_frame(60, 60);
		queue_rx_frame(60, 1'b1);
		queue_random_traffic(30);
		drain_sender();
		@(negedge clk);
		calm = 1'b1;
		queue_random_traffic(40);
		drain_sender();
		@(negedge clk);
		calm = 1'b0;
		queue_random_traffic(30);
		drain_sender();
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (errors == 0 && expected_beats.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
